@@ hdl/binary_majority_filter_3x3_assert.svh @@
// assertion macros shared by the binary majority filter modules
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef BINARY_MAJORITY_FILTER_3X3_ASSERT_SVH
`define BINARY_MAJORITY_FILTER_3X3_ASSERT_SVH

`ifndef SYNTHESIS

`define BMF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define BMF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BMF_ASSERT_IMP(label, ante, cons, msg)

`define BMF_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

@@ hdl/bmf_pkg.sv @@
// shared types, constants and helpers for the binary majority filter
// no dependencies
package bmf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int WEFF_W      = ADDR_W + 1;
  localparam int ROW_WIDTH_W = 11;
  localparam int ROW_COUNT_W = 13;
  localparam int ROW_W       = 13;
  localparam int HPLUS_W     = ROW_COUNT_W + 1;
  localparam int THRESH_W    = 4;
  localparam int WIN_W       = 9;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_ADDR_W-1:0] REG_ROW_WIDTH      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FULL_THRESHOLD = 2'd2;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST      = 11'd64;
  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST      = 13'd64;
  localparam logic [THRESH_W-1:0]    FULL_THRESHOLD_RST = 4'd5;

  typedef struct packed {
    logic cell_req;
    logic drain;
  } src_item_t;

  typedef struct packed {
    logic cell_out;
    logic last_of_frame;
  } res_item_t;

  // one entry of the line ram: the cell two rows up and one row up
  typedef struct packed {
    logic upper;
    logic middle;
  } row_pair_t;

  // per-item control decided from the raster position at acceptance
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              cur_cell;
    logic              use_upper;
    logic              use_middle;
    logic              col_first;
    logic              emit;
    logic              last;
    logic              frame_end;
  } tap_ctl_t;

  function automatic logic [THRESH_W-1:0] count_full(input logic [WIN_W-1:0] w);
    logic [THRESH_W-1:0] n;
    n = '0;
    for (int i = 0; i < WIN_W; i++) begin
      n = n + THRESH_W'(w[i]);
    end
    return n;
  endfunction

endpackage

@@ hdl/bmf_row_ram.sv @@
// line buffer ram holding the two previous rows, one 2-bit entry per column
// depends on bmf_pkg
module bmf_row_ram (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [bmf_pkg::ADDR_W-1:0] rd_addr,
  output bmf_pkg::row_pair_t         rd_data,
  input  logic                       wr_en,
  input  logic [bmf_pkg::ADDR_W-1:0] wr_addr,
  input  bmf_pkg::row_pair_t         wr_data
);

  bmf_pkg::row_pair_t mem [bmf_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/bmf_ctrl.sv @@
// configuration registers and raster position tracking for the majority filter
// depends on bmf_pkg and the assertion macro header
`include "binary_majority_filter_3x3_assert.svh"

module bmf_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           src_valid,
  input  bmf_pkg::src_item_t             src_item,
  input  logic                           accept_ok,
  output logic                           take,
  output bmf_pkg::tap_ctl_t              tap,
  output logic [bmf_pkg::THRESH_W-1:0]   threshold,
  input  logic                           cfg_we,
  input  logic [bmf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bmf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [bmf_pkg::ROW_WIDTH_W-1:0] row_width;
  logic [bmf_pkg::ROW_COUNT_W-1:0] row_count;
  logic [bmf_pkg::THRESH_W-1:0]    full_threshold;
  logic [bmf_pkg::ADDR_W-1:0]      col;
  logic [bmf_pkg::ROW_W-1:0]       row;
  logic [bmf_pkg::ADDR_W-1:0]      col_next;
  logic [bmf_pkg::ROW_W-1:0]       row_next;

  logic [bmf_pkg::WEFF_W-1:0]      w_eff;
  logic [bmf_pkg::ROW_COUNT_W-1:0] h_eff;
  logic [bmf_pkg::HPLUS_W-1:0]     h_plus1;
  logic [bmf_pkg::HPLUS_W-1:0]     row_x;
  logic [bmf_pkg::ADDR_W-1:0]      col_cur;
  logic [bmf_pkg::WEFF_W-1:0]      col_inc;
  logic                            row_ge2;

  always_comb begin
    if (row_width == '0) begin
      w_eff = bmf_pkg::WEFF_W'(1);
    end else if (int'(row_width) > bmf_pkg::MAX_WIDTH) begin
      w_eff = bmf_pkg::WEFF_W'(bmf_pkg::MAX_WIDTH);
    end else begin
      w_eff = bmf_pkg::WEFF_W'(row_width);
    end
    h_eff   = (row_count == '0) ? bmf_pkg::ROW_COUNT_W'(1) : row_count;
    h_plus1 = {1'b0, h_eff} + bmf_pkg::HPLUS_W'(1);
    row_x   = {1'b0, row};
    col_cur = ({1'b0, col} >= w_eff) ? '0 : col;
    row_ge2 = (row >= bmf_pkg::ROW_W'(2));

    tap            = '0;
    tap.addr       = col_cur;
    tap.cur_cell   = src_item.cell_req & ~src_item.drain & (row < h_eff);
    tap.use_upper  = row_ge2;
    tap.use_middle = (row != '0);
    tap.col_first  = (col_cur == '0);

    // first column closes the window of the last cell two rows up
    if (tap.col_first) begin
      if (row_ge2) begin
        priority if (row_x == h_plus1) begin
          tap.emit      = 1'b1;
          tap.last      = 1'b1;
          tap.frame_end = 1'b1;
        end else if (row_x > h_plus1) begin
          tap.frame_end = 1'b1;
        end else begin
          tap.emit      = 1'b1;
        end
      end
    end else begin
      tap.emit = (row != '0) && (row_x < h_plus1);
    end

    col_inc = {1'b0, col_cur} + bmf_pkg::WEFF_W'(1);
    if (tap.frame_end) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = row + bmf_pkg::ROW_W'(1);
    end else begin
      col_next = col_inc[bmf_pkg::ADDR_W-1:0];
      row_next = row;
    end
  end

  assign take      = src_valid && accept_ok;
  assign threshold = full_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width      <= bmf_pkg::ROW_WIDTH_RST;
      row_count      <= bmf_pkg::ROW_COUNT_RST;
      full_threshold <= bmf_pkg::FULL_THRESHOLD_RST;
      col            <= '0;
      row            <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bmf_pkg::REG_ROW_WIDTH: begin
          row_width <= cfg_wdata[bmf_pkg::ROW_WIDTH_W-1:0];
        end
        bmf_pkg::REG_ROW_COUNT: begin
          row_count <= cfg_wdata[bmf_pkg::ROW_COUNT_W-1:0];
        end
        bmf_pkg::REG_FULL_THRESHOLD: begin
          full_threshold <= cfg_wdata[bmf_pkg::THRESH_W-1:0];
        end
        default: begin
        end
      endcase
      // any write restarts the frame
      col <= '0;
      row <= '0;
    end else if (take) begin
      col <= col_next;
      row <= row_next;
    end
  end

  `BMF_ASSERT_IMP(a_col_in_row, 1'b1, {1'b0, col} < w_eff, "column beyond row width")
  `BMF_ASSERT_IMP(a_row_bound, 1'b1, row_x <= h_plus1, "row counter ran past the flush row")

endmodule

@@ hdl/bmf_window.sv @@
// ram read stage, 3x3 window shift register, majority decision and result register
// depends on bmf_pkg and the assertion macro header
`include "binary_majority_filter_3x3_assert.svh"

module bmf_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         restart,
  input  logic                         take,
  input  bmf_pkg::tap_ctl_t            tap_in,
  input  logic [bmf_pkg::THRESH_W-1:0] threshold,
  output logic                         accept_ok,
  input  bmf_pkg::row_pair_t           ram_rd_data,
  output logic                         ram_wr_en,
  output logic [bmf_pkg::ADDR_W-1:0]   ram_wr_addr,
  output bmf_pkg::row_pair_t           ram_wr_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output bmf_pkg::res_item_t           res_item
);

  logic                       s1_valid;
  bmf_pkg::tap_ctl_t          s1;
  logic                       fwd_valid;
  bmf_pkg::row_pair_t         fwd_data;
  logic [bmf_pkg::WIN_W-1:0]  window;
  logic [bmf_pkg::WIN_W-1:0]  window_next;
  logic [bmf_pkg::WIN_W-1:0]  centre;
  bmf_pkg::row_pair_t         stored;
  logic [2:0]                 col_bits;
  logic                       out_free;
  logic                       s1_fire;
  logic                       full_bit;

  always_comb begin
    // a one-column row rewrites the entry the next item reads
    stored   = fwd_valid ? fwd_data : ram_rd_data;
    col_bits = {s1.cur_cell, s1.use_middle & stored.middle, s1.use_upper & stored.upper};
    if (s1.col_first) begin
      centre      = {3'b000, window[bmf_pkg::WIN_W-1:3]};
      window_next = {col_bits, 6'b000000};
    end else begin
      window_next = {col_bits, window[bmf_pkg::WIN_W-1:3]};
      centre      = window_next;
    end
    if (s1.frame_end) begin
      window_next = '0;
    end
    full_bit = (bmf_pkg::count_full(centre) >= threshold);
  end

  assign out_free    = !res_valid || res_ready;
  assign s1_fire     = s1_valid && (!s1.emit || out_free);
  assign accept_ok   = !s1_valid || s1_fire;
  assign ram_wr_en   = s1_fire;
  assign ram_wr_addr = s1.addr;
  assign ram_wr_data = '{upper: stored.middle, middle: s1.cur_cell};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      window    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid  <= 1'b1;
        fwd_valid <= s1_fire && (s1.addr == tap_in.addr);
      end else if (s1_fire) begin
        s1_valid  <= 1'b0;
      end
      if (restart) begin
        window <= '0;
      end else if (s1_fire) begin
        window <= window_next;
      end
      if (s1_fire && s1.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1       <= tap_in;
      fwd_data <= ram_wr_data;
    end
    if (s1_fire && s1.emit) begin
      res_item <= '{cell_out: full_bit, last_of_frame: s1.last};
    end
  end

  `BMF_ASSERT_NXT(a_restart_clears, restart, window == '0, "window not cleared on restart")
  `BMF_ASSERT_NXT(a_stage_holds, s1_valid && !s1_fire, s1_valid && $stable(s1),
                  "stalled item lost from read stage")
  `BMF_ASSERT_NXT(a_frame_end_clears, s1_fire && s1.frame_end && !take, window == '0,
                  "window not cleared at frame end")

endmodule

@@ hdl/binary_majority_filter_3x3.sv @@
// One smoothing pass of a binary cellular automaton over a raster-order grid: each output
// cell is full when the number of full cells in its 3x3 neighborhood (itself included,
// outside-grid positions empty) reaches full_threshold. The block takes one item per clock
// whenever the result register is free; the limit is the single read-modify-write of the
// line ram per item, with forwarding covering one-column rows. The result for cell q
// is computed when item q + row_width + 1 leaves the read stage and is then held in the
// result register, so feed row_width + 1 drain items after the last cell to flush a frame.
// The line ram needs no clearing pass.
// Depends on bmf_pkg, bmf_ctrl, bmf_row_ram and bmf_window.
module binary_majority_filter_3x3 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           src_valid,
  output logic                           src_ready,
  input  bmf_pkg::src_item_t             src_item,
  output logic                           res_valid,
  input  logic                           res_ready,
  output bmf_pkg::res_item_t             res_item,
  input  logic                           cfg_we,
  input  logic [bmf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bmf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                         accept_ok;
  logic                         take;
  bmf_pkg::tap_ctl_t            tap;
  logic [bmf_pkg::THRESH_W-1:0] threshold;
  bmf_pkg::row_pair_t           ram_rd_data;
  logic                         ram_wr_en;
  logic [bmf_pkg::ADDR_W-1:0]   ram_wr_addr;
  bmf_pkg::row_pair_t           ram_wr_data;

  assign src_ready = accept_ok;

  bmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_item  (src_item),
    .accept_ok (accept_ok),
    .take      (take),
    .tap       (tap),
    .threshold (threshold),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  bmf_row_ram u_ram (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (tap.addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  bmf_window u_window (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_we),
    .take        (take),
    .tap_in      (tap),
    .threshold   (threshold),
    .accept_ok   (accept_ok),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_item    (res_item)
  );

endmodule
